// ===== rtl/pcc_pkg.sv =====
// Shared constants and types of the clamped PID controller.
package pcc_pkg;

    localparam int MEASURE_WIDTH = 16;
    localparam int DRIVE_WIDTH   = 26;
    localparam int GAIN_WIDTH    = 16;
    localparam int LIMIT_WIDTH   = 31;
    localparam int INTEG_WIDTH   = 32;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 31;
    localparam int QUEUE_DEPTH   = 4;

    localparam int DIV_SHIFT     = 37;
    localparam logic [LIMIT_WIDTH-1:0] DIV_MAGIC = 31'h51EB_851F;
    localparam int DRIVE_MAX     = 21474836;

    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_LIM = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_LIM   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_USE_D     = 3'd5;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0]  gain_p;
        logic [GAIN_WIDTH-1:0]  gain_i;
        logic [GAIN_WIDTH-1:0]  gain_d;
        logic [LIMIT_WIDTH-1:0] integral_limit;
        logic [LIMIT_WIDTH-1:0] output_limit;
        logic                   use_derivative;
    } pcc_cfg_t;

endpackage

// ===== rtl/pid_controller_clamped_core.sv =====
// Top level of the clamped PID controller: configuration registers and part wiring.
//
// Integer PID regulator with anti-windup clamp. One step item is taken per clock
// cycle while the queue is not full: the front part forms the error and its
// difference in the cycle of acceptance, a four-entry queue follows, and a
// six-stage back pipeline forms the products, the clamped integral (a loop
// through the integral register), the output sum and clamp, and the divide
// by 100 by reciprocal multiplication. A clear item zeroes the integral in order
// with the steps around it and yields no drive item. Stall on the drive side holds
// the back pipeline; steps are still accepted until the queue fills. Configuration
// is written through cfg_valid/cfg_ready, always ready, and takes effect at once,
// so write it only while no item is in flight.
module pid_controller_clamped_core #(
    parameter int MEASURE_WIDTH = pcc_pkg::MEASURE_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   action,
    input  logic signed [MEASURE_WIDTH-1:0]        setpoint,
    input  logic signed [MEASURE_WIDTH-1:0]        measured,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pcc_pkg::DRIVE_WIDTH-1:0] drive,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pcc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int QW = 2 * MEASURE_WIDTH + 4;

    pcc_pkg::pcc_cfg_t cfg_reg;
    pcc_pkg::pcc_cfg_t cfg_next;

    logic          push;
    logic [QW-1:0] push_data;
    logic          pop;
    logic [QW-1:0] pop_data;
    logic          q_not_empty;
    logic          q_full;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pcc_pkg::REG_GAIN_P:
                begin
                    cfg_next.gain_p = cfg_data[pcc_pkg::GAIN_WIDTH-1:0];
                end
                pcc_pkg::REG_GAIN_I:
                begin
                    cfg_next.gain_i = cfg_data[pcc_pkg::GAIN_WIDTH-1:0];
                end
                pcc_pkg::REG_GAIN_D:
                begin
                    cfg_next.gain_d = cfg_data[pcc_pkg::GAIN_WIDTH-1:0];
                end
                pcc_pkg::REG_INTEG_LIM:
                begin
                    cfg_next.integral_limit = cfg_data[pcc_pkg::LIMIT_WIDTH-1:0];
                end
                pcc_pkg::REG_OUT_LIM:
                begin
                    cfg_next.output_limit = cfg_data[pcc_pkg::LIMIT_WIDTH-1:0];
                end
                pcc_pkg::REG_USE_D:
                begin
                    cfg_next.use_derivative = cfg_data[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{gain_p: '0, gain_i: '0, gain_d: '0,
                         integral_limit: '0, output_limit: '0,
                         use_derivative: 1'b1};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pcc_front #(
        .MEASURE_WIDTH (MEASURE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .setpoint   (setpoint),
        .measured   (measured),
        .queue_full (q_full),
        .push       (push),
        .push_data  (push_data)
    );

    pcc_queue #(
        .WIDTH (QW),
        .DEPTH (pcc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    pcc_back #(
        .MEASURE_WIDTH (MEASURE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_not_empty),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive)
    );

    a_hold_pipe_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !pop)
        else $error("queue popped while drive item stalled");

    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive <= pcc_pkg::DRIVE_MAX) && (drive >= -pcc_pkg::DRIVE_MAX))
        else $error("drive item outside clamped range");

    a_cfg_use_d_written: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && (cfg_index == pcc_pkg::REG_USE_D)
        |=> cfg_reg.use_derivative == $past(cfg_data[0]))
        else $error("derivative select not taken from write");

endmodule

// ===== rtl/pcc_queue.sv =====
// Small register queue between the front and back parts.
module pcc_queue #(
    parameter int WIDTH = 35,
    parameter int DEPTH = pcc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (32'(count_reg) == DEPTH);

endmodule

// ===== rtl/pcc_front.sv =====
// Front part: accepts step items, forms error and error difference.
module pcc_front #(
    parameter int MEASURE_WIDTH = pcc_pkg::MEASURE_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic signed [MEASURE_WIDTH-1:0] setpoint,
    input  logic signed [MEASURE_WIDTH-1:0] measured,
    input  logic                            queue_full,
    output logic                            push,
    output logic [2*MEASURE_WIDTH+3:0]      push_data
);

    localparam int EW = MEASURE_WIDTH + 1;
    localparam int DW = MEASURE_WIDTH + 2;

    logic signed [EW-1:0] prev_error_reg;
    logic signed [EW-1:0] prev_error_next;
    logic signed [EW-1:0] err_w;
    logic signed [DW-1:0] derr_w;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;
    assign err_w    = EW'(setpoint) - EW'(measured);
    assign derr_w   = DW'(err_w) - DW'(prev_error_reg);

    always_comb
    begin
        prev_error_next = prev_error_reg;
        if (push && !action)
        begin
            prev_error_next = err_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg <= '0;
        end
        else
        begin
            prev_error_reg <= prev_error_next;
        end
    end

    assign push_data = {action, err_w, derr_w};

endmodule

// ===== rtl/pcc_back.sv =====
// Back part: products, integral clamp, output sum, clamp and scale-down pipeline.
module pcc_back #(
    parameter int MEASURE_WIDTH = pcc_pkg::MEASURE_WIDTH
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  pcc_pkg::pcc_cfg_t                        cfg,
    input  logic                                     q_valid,
    input  logic [2*MEASURE_WIDTH+3:0]               q_data,
    output logic                                     pop,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [pcc_pkg::DRIVE_WIDTH-1:0]   drive
);

    localparam int EW    = MEASURE_WIDTH + 1;
    localparam int DW    = MEASURE_WIDTH + 2;
    localparam int PW    = pcc_pkg::GAIN_WIDTH + 1 + EW;
    localparam int DPW   = pcc_pkg::GAIN_WIDTH + 1 + DW;
    localparam int W     = ((MEASURE_WIDTH > 13) ? MEASURE_WIDTH : 13) + 21;
    localparam int LW    = pcc_pkg::LIMIT_WIDTH;
    localparam int IW    = pcc_pkg::INTEG_WIDTH;
    localparam int PRW   = 2 * pcc_pkg::LIMIT_WIDTH;
    localparam int QW    = PRW - pcc_pkg::DIV_SHIFT;
    localparam int OW    = pcc_pkg::DRIVE_WIDTH;

    logic                 en;
    logic                 q_clear;
    logic signed [EW-1:0] q_err;
    logic signed [DW-1:0] q_derr;

    logic signed [PW-1:0]  pi_w;
    logic signed [PW-1:0]  pp_w;
    logic signed [DPW-1:0] pd_w;

    logic                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_valid_reg;
    logic                clr1_reg;
    logic signed [W-1:0] pi1_reg, pp1_reg, pd1_reg;
    logic signed [W-1:0] pe2_reg;
    logic signed [W-1:0] sum3_reg;
    logic                neg4_reg, neg5_reg;
    logic [LW-1:0]       mag4_reg;
    logic [PRW-1:0]      prod5_reg;
    logic signed [OW-1:0] drive_reg;

    logic signed [IW-1:0] integ_reg;
    logic signed [IW-1:0] integ_next;
    logic signed [W-1:0]  integ_tmp;
    logic signed [W-1:0]  ilim_x;
    logic signed [W-1:0]  olim_x;
    logic                 neg4_next;
    logic [LW-1:0]        mag4_next;
    logic signed [W-1:0]  sum3_abs;
    logic [QW-1:0]        quot_w;
    logic signed [OW-1:0] drive_next;

    assign en      = !(out_valid_reg && out_stall);
    assign pop     = en && q_valid;
    assign q_clear = q_data[EW+DW];
    assign q_err   = $signed(q_data[EW+DW-1:DW]);
    assign q_derr  = $signed(q_data[DW-1:0]);

    assign pi_w = $signed({1'b0, cfg.gain_i}) * q_err;
    assign pp_w = $signed({1'b0, cfg.gain_p}) * q_err;
    assign pd_w = $signed({1'b0, cfg.gain_d}) * q_derr;

    assign ilim_x    = W'({1'b0, cfg.integral_limit});
    assign olim_x    = W'({1'b0, cfg.output_limit});
    assign integ_tmp = W'(integ_reg) + pi1_reg;

    always_comb
    begin
        integ_next = integ_reg;
        if (en && v1_reg)
        begin
            if (clr1_reg)
            begin
                integ_next = '0;
            end
            else if (integ_tmp > ilim_x)
            begin
                integ_next = IW'(ilim_x);
            end
            else if (integ_tmp < -ilim_x)
            begin
                integ_next = IW'(-ilim_x);
            end
            else
            begin
                integ_next = IW'(integ_tmp);
            end
        end
    end

    assign sum3_abs = sum3_reg[W-1] ? -sum3_reg : sum3_reg;

    always_comb
    begin
        if (sum3_reg > olim_x)
        begin
            neg4_next = 1'b0;
            mag4_next = cfg.output_limit;
        end
        else if (sum3_reg < -olim_x)
        begin
            neg4_next = 1'b1;
            mag4_next = cfg.output_limit;
        end
        else
        begin
            neg4_next = sum3_reg[W-1];
            mag4_next = sum3_abs[LW-1:0];
        end
    end

    assign quot_w     = prod5_reg[PRW-1:pcc_pkg::DIV_SHIFT];
    assign drive_next = neg5_reg ? -OW'({1'b0, quot_w}) : OW'({1'b0, quot_w});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
        end
        else
        begin
            integ_reg <= integ_next;
            if (en)
            begin
                v1_reg        <= q_valid;
                v2_reg        <= v1_reg && !clr1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                v5_reg        <= v4_reg;
                out_valid_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clr1_reg  <= q_clear;
            pi1_reg   <= W'(pi_w);
            pp1_reg   <= W'(pp_w);
            pd1_reg   <= cfg.use_derivative ? W'(pd_w) : '0;
            pe2_reg   <= pp1_reg + pd1_reg;
            sum3_reg  <= pe2_reg + W'(integ_reg);
            neg4_reg  <= neg4_next;
            mag4_reg  <= mag4_next;
            neg5_reg  <= neg4_reg;
            prod5_reg <= PRW'(mag4_reg) * PRW'(pcc_pkg::DIV_MAGIC);
            drive_reg <= drive_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule

// ===== dv/tb_pid_controller_clamped_core.sv =====
// Self-checking testbench for the clamped PID controller core.
`timescale 1ns / 1ps

module tb_pid_controller_clamped_core;

    localparam int MW          = pcc_pkg::MEASURE_WIDTH;
    localparam int DRW         = pcc_pkg::DRIVE_WIDTH;
    localparam int CIW         = pcc_pkg::CFG_INDEX_W;
    localparam int CDW         = pcc_pkg::CFG_DATA_W;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 20;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 240;

    localparam logic [CIW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CIW-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic {
        ACT_STEP  = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

    typedef struct packed {
        action_t                action;
        logic signed [MW-1:0]   setpoint;
        logic signed [MW-1:0]   measured;
    } step_item_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic                            action = 1'b0;
    logic signed [MW-1:0]            setpoint = '0;
    logic signed [MW-1:0]            measured = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic signed [DRW-1:0]           drive;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [CIW-1:0]                  cfg_index = '0;
    logic [CDW-1:0]                  cfg_data = '0;

    step_item_t                      step_queue[$];
    logic signed [DRW-1:0]           drive_expected[$];

    longint                          kp = 0;
    longint                          ki = 0;
    longint                          kd = 0;
    longint                          integ_lim = 0;
    longint                          out_lim = 0;
    bit                              pid_mode = 1'b1;
    longint                          err_prev = 0;
    longint                          integ_acc = 0;

    int                              sender_idle_pct = 0;
    int                              stall_pct = 0;
    bit                              sender_hold = 1'b0;
    int                              holds_asked = 0;
    int                              holds_served = 0;
    int                              hold_left = 0;
    int                              mismatches = 0;
    int unsigned                     cycle_count = 0;

    pid_controller_clamped_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .setpoint  (setpoint),
        .measured  (measured),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v < -lim)
            return -lim;
        if (v > lim)
            return lim;
        return v;
    endfunction

    function automatic void advance_pid(input step_item_t it);
        longint err;
        longint derr;
        longint total;
        longint scaled;
        if (it.action == ACT_CLEAR)
        begin
            integ_acc = 0;
            return;
        end
        err        = longint'(it.setpoint) - longint'(it.measured);
        derr       = err - err_prev;
        err_prev   = err;
        integ_acc  = clamp_sym(integ_acc + ki * err, integ_lim);
        total      = kp * err + integ_acc;
        if (pid_mode)
            total += kd * derr;
        scaled = clamp_sym(total, out_lim) / 100;
        drive_expected.push_back(scaled[DRW-1:0]);
    endfunction

    // drive one item per accepted handshake, noise on the payload while idle
    always @(posedge clk or negedge rst_n)
    begin
        step_item_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                advance_pid(step_item_t'{action_t'(action), setpoint, measured});
            if (!in_valid || !in_stall)
            begin
                if (step_queue.size() != 0 && !sender_hold
                    && $urandom_range(99) >= sender_idle_pct)
                begin
                    nxt = step_queue.pop_front();
                    in_valid <= 1'b1;
                    action   <= nxt.action;
                    setpoint <= nxt.setpoint;
                    measured <= nxt.measured;
                end
                else
                begin
                    in_valid <= 1'b0;
                    action   <= 1'($urandom);
                    setpoint <= MW'($urandom);
                    measured <= MW'($urandom);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else if (holds_served != holds_asked)
        begin
            out_stall    <= 1'b1;
            hold_left    <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        logic signed [DRW-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_expected.size() == 0)
            begin
                $error("drive: no item expected, got %0d", drive);
                mismatches++;
            end
            else
            begin
                want = drive_expected.pop_front();
                if (drive !== want)
                begin
                    $error("drive: expected %0d, got %0d", want, drive);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic write_reg(input logic [CIW-1:0] idx,
                             input logic [CDW-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pcc_pkg::REG_GAIN_P:    kp        = longint'(data[pcc_pkg::GAIN_WIDTH-1:0]);
            pcc_pkg::REG_GAIN_I:    ki        = longint'(data[pcc_pkg::GAIN_WIDTH-1:0]);
            pcc_pkg::REG_GAIN_D:    kd        = longint'(data[pcc_pkg::GAIN_WIDTH-1:0]);
            pcc_pkg::REG_INTEG_LIM: integ_lim = longint'(data[pcc_pkg::LIMIT_WIDTH-1:0]);
            pcc_pkg::REG_OUT_LIM:   out_lim   = longint'(data[pcc_pkg::LIMIT_WIDTH-1:0]);
            pcc_pkg::REG_USE_D:     pid_mode  = data[0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [CDW-1:0] p, input logic [CDW-1:0] i,
                               input logic [CDW-1:0] d, input logic [CDW-1:0] il,
                               input logic [CDW-1:0] ol, input logic [CDW-1:0] pid);
        write_reg(pcc_pkg::REG_GAIN_P, p);
        write_reg(pcc_pkg::REG_GAIN_I, i);
        write_reg(pcc_pkg::REG_GAIN_D, d);
        write_reg(pcc_pkg::REG_INTEG_LIM, il);
        write_reg(pcc_pkg::REG_OUT_LIM, ol);
        write_reg(pcc_pkg::REG_USE_D, pid);
    endtask

    function automatic logic [CDW-1:0] pick_gain();
        case ($urandom_range(5))
            0:       return '0;
            1:       return CDW'(65535);
            2:       return CDW'($urandom);
            default: return CDW'($urandom_range(0, 800));
        endcase
    endfunction

    function automatic logic [CDW-1:0] pick_limit();
        case ($urandom_range(6))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            2:       return CDW'($urandom);
            3:       return CDW'($urandom_range(0, 50000000));
            default: return CDW'($urandom_range(0, 400000));
        endcase
    endfunction

    function automatic logic signed [MW-1:0] pick_level();
        case ($urandom_range(11))
            0:       return {1'b1, {(MW-1){1'b0}}};
            1:       return {1'b0, {(MW-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            4:       return MW'($urandom_range(0, 2000)) - MW'(1000);
            default: return MW'($urandom);
        endcase
    endfunction

    function automatic step_item_t random_step();
        step_item_t it;
        it.action   = ($urandom_range(99) < 6) ? ACT_CLEAR : ACT_STEP;
        it.setpoint = pick_level();
        if ($urandom_range(99) < 45)
            it.measured = it.setpoint + MW'($urandom_range(0, 400)) - MW'(200);
        else
            it.measured = pick_level();
        return it;
    endfunction

    task automatic push_item(input action_t act, input logic signed [MW-1:0] sp,
                             input logic signed [MW-1:0] ms);
        step_queue.push_back(step_item_t'{act, sp, ms});
    endtask

    task automatic drain();
        while (step_queue.size() != 0 || in_valid || drive_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        int idle_tbl[4];
        int stall_tbl[4];
        idle_tbl  = '{0, 65, 0, 38};
        stall_tbl = '{0, 0, 65, 38};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full gains and limits, spare indexes
        write_reg(REG_SPARE_LO, CDW'($urandom));
        write_reg(REG_SPARE_HI, CDW'($urandom));
        load_config(65535, 65535, 65535, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1);
        push_item(ACT_STEP, 32767, -32768);
        push_item(ACT_STEP, -32768, 32767);
        push_item(ACT_STEP, 0, 0);
        push_item(ACT_CLEAR, 12345, -54);
        push_item(ACT_STEP, 32767, -32768);
        push_item(ACT_STEP, -1, -1);
        push_item(ACT_STEP, -32768, -32768);
        drain();

        // zero limits
        load_config(100, 100, 100, 0, 0, 1);
        push_item(ACT_STEP, 30000, -30000);
        push_item(ACT_STEP, -30000, 30000);
        push_item(ACT_STEP, 7, 3);
        drain();

        // PI mode, truncation toward zero on negative sums
        load_config(1, 3, 65535, 5000, 1000000, 0);
        push_item(ACT_STEP, -150, 0);
        push_item(ACT_STEP, 150, 0);
        push_item(ACT_STEP, 32767, -32768);
        push_item(ACT_CLEAR, 0, 0);
        push_item(ACT_STEP, -99, 0);
        push_item(ACT_STEP, -32768, 32767);
        drain();

        // all gains zero
        load_config(0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1);
        push_item(ACT_STEP, 32767, -32768);
        push_item(ACT_STEP, -32768, 32767);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            sender_idle_pct = idle_tbl[ph % 4];
            stall_pct       = stall_tbl[ph % 4];
            load_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit(),
                        CDW'($urandom));
            @(negedge clk);
            if (ph == 4)
                holds_asked = holds_asked + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                step_queue.push_back(random_step());
            if (ph == 5)
            begin
                while (step_queue.size() > PHASE_ITEMS / 2)
                    @(negedge clk);
                sender_hold = 1'b1;
                while (in_valid || drive_expected.size() != 0)
                    @(negedge clk);
                repeat (SETTLE) @(negedge clk);
                sender_hold = 1'b0;
            end
            drain();
        end

        if (drive_expected.size() != 0)
        begin
            $error("drive: %0d items never arrived", drive_expected.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pcc_pkg.sv
rtl/pcc_queue.sv
rtl/pcc_front.sv
rtl/pcc_back.sv
rtl/pid_controller_clamped_core.sv
dv/tb_pid_controller_clamped_core.sv
